### src/gcrg_pkg.sv
// Shared types and constants for the grid cell read and gradient block.
`timescale 1ns / 1ps
`default_nettype none

package gcrg_pkg;

    // Default sizes of the grid store.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed widths of the command and result words.
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 7;
    localparam int COL_W       = 7;
    localparam int IN_VALUE_W  = 16;
    localparam int OUT_VALUE_W = 16;
    localparam int GRAD_W      = 17;

    // Row times width plus column stays below 2**15 for 7-bit indices and 8-bit widths.
    localparam int ADDR_CALC_W = 15;

    // Smallest grid side; smaller settings saturate to it.
    localparam int MIN_SIZE = 3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 8'd128;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH    = 2'd0,
        CFG_GRID_HEIGHT   = 2'd1,
        CFG_SAFE_GRADIENT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_GRAD  = 2'd2
    } req_kind_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        req_kind_t                     kind;
        logic                          access;  // memory is touched for this request
        logic                          status;  // index outside the configured grid
        logic [ROW_W-1:0]              row;     // clamped row for clamp-mode gradients
        logic [COL_W-1:0]              col;
        logic signed [IN_VALUE_W-1:0]  value;
    } desc_t;

endpackage

`default_nettype wire

### src/gcrg_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gcrg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### src/gcrg_front.sv
// Front end: configuration registers, command acceptance and request classification.
`timescale 1ns / 1ps
`default_nettype none

module gcrg_front #(
    parameter int MAX_WIDTH  = gcrg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gcrg_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr,
    input  wire logic [gcrg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gcrg_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                  start,
    input  wire logic [1:0]                            req_type,
    input  wire logic [gcrg_pkg::ROW_W-1:0]            row,
    input  wire logic [gcrg_pkg::COL_W-1:0]            col,
    input  wire logic signed [gcrg_pkg::IN_VALUE_W-1:0] cell_value,
    input  wire logic                                  q_full,
    output logic                                       busy,
    output logic                                       push,
    output gcrg_pkg::desc_t                            push_data,
    output logic [gcrg_pkg::CFG_W-1:0]                 eff_w
);
    import gcrg_pkg::*;

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic             safe_gradient_reg;

    logic [CFG_W-1:0] eff_h;
    logic [CFG_W-1:0] row_ext;
    logic [CFG_W-1:0] col_ext;
    logic [CFG_W-1:0] row_clamp;
    logic [CFG_W-1:0] col_clamp;
    logic             in_grid;
    logic             interior;
    req_kind_t        kind;
    logic             kind_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= GRID_SIZE_RESET;
            grid_height_reg   <= GRID_SIZE_RESET;
            safe_gradient_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GRID_WIDTH:    grid_width_reg    <= cfg_data;
                CFG_GRID_HEIGHT:   grid_height_reg   <= cfg_data;
                CFG_SAFE_GRADIENT: safe_gradient_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Saturate the configured sizes into the range the store supports.
    always_comb
    begin
        if (grid_width_reg < CFG_W'(MIN_SIZE))
        begin
            eff_w = CFG_W'(MIN_SIZE);
        end
        else if (int'(grid_width_reg) > MAX_WIDTH)
        begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = grid_width_reg;
        end

        if (grid_height_reg < CFG_W'(MIN_SIZE))
        begin
            eff_h = CFG_W'(MIN_SIZE);
        end
        else if (int'(grid_height_reg) > MAX_HEIGHT)
        begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = grid_height_reg;
        end
    end

    assign row_ext  = CFG_W'(row);
    assign col_ext  = CFG_W'(col);
    assign in_grid  = (row_ext < eff_h) && (col_ext < eff_w);
    assign interior = (row_ext >= 8'd1) && ((row_ext + 8'd1) < eff_h)
                   && (col_ext >= 8'd1) && ((col_ext + 8'd1) < eff_w);

    // Clamp to [1, size-2]; the result always fits the index width.
    always_comb
    begin
        row_clamp = row_ext;
        col_clamp = col_ext;
        if (row_clamp < 8'd1)
        begin
            row_clamp = 8'd1;
        end
        if (row_clamp > (eff_h - 8'd2))
        begin
            row_clamp = eff_h - 8'd2;
        end
        if (col_clamp < 8'd1)
        begin
            col_clamp = 8'd1;
        end
        if (col_clamp > (eff_w - 8'd2))
        begin
            col_clamp = eff_w - 8'd2;
        end
    end

    assign kind    = req_kind_t'(req_type);
    assign kind_ok = (kind inside {REQ_WRITE, REQ_READ, REQ_GRAD});
    assign busy    = q_full;
    assign push    = start && !q_full && kind_ok;

    always_comb
    begin
        push_data.kind   = kind;
        push_data.value  = cell_value;
        push_data.row    = row;
        push_data.col    = col;
        push_data.access = in_grid;
        push_data.status = 1'b0;
        case (kind)
            REQ_WRITE:
            begin
                push_data.access = in_grid;
            end
            REQ_READ:
            begin
                push_data.status = !in_grid;
            end
            REQ_GRAD:
            begin
                if (safe_gradient_reg)
                begin
                    push_data.access = interior;
                end
                else
                begin
                    push_data.status = !in_grid;
                    push_data.row    = row_clamp[ROW_W-1:0];
                    push_data.col    = col_clamp[COL_W-1:0];
                end
            end
            default:
            begin
                push_data.access = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/gcrg_queue.sv
// Short FIFO of classified requests between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module gcrg_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire gcrg_pkg::desc_t push_data,
    input  wire logic            pop,
    output gcrg_pkg::desc_t      pop_data,
    output logic                 full,
    output logic                 empty
);
    import gcrg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

### src/gcrg_back.sv
// Back end: sequences memory accesses for one request and forms the result word.
`timescale 1ns / 1ps
`default_nettype none

module gcrg_back #(
    parameter int VALUE_BITS = gcrg_pkg::DEF_VALUE_BITS,
    parameter int ADDR_W     = 14
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   q_empty,
    input  wire gcrg_pkg::desc_t                        q_data,
    output logic                                        q_pop,
    input  wire logic [gcrg_pkg::CFG_W-1:0]             eff_w,
    output logic                                        ram_we,
    output logic                                        ram_re,
    output logic [ADDR_W-1:0]                           ram_addr,
    output logic [VALUE_BITS-1:0]                       ram_wdata,
    input  wire logic [VALUE_BITS-1:0]                  ram_rdata,
    output logic                                        result_valid,
    output logic signed [gcrg_pkg::OUT_VALUE_W-1:0]     read_value,
    output logic signed [gcrg_pkg::GRAD_W-1:0]          grad_x,
    output logic signed [gcrg_pkg::GRAD_W-1:0]          grad_y,
    output logic                                        status
);
    import gcrg_pkg::*;

    localparam int DIFF_W = (VALUE_BITS + 1 > GRAD_W) ? VALUE_BITS + 1 : GRAD_W;
    localparam int RV_W   = (VALUE_BITS > OUT_VALUE_W) ? VALUE_BITS : OUT_VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [1:0]                      step_reg;
    logic                            pend_reg;
    logic [1:0]                      pend_step_reg;
    desc_t                           desc_reg;
    logic signed [VALUE_BITS-1:0]    hold_reg;
    logic signed [GRAD_W-1:0]        gx_reg;
    logic                            result_valid_reg;
    logic signed [OUT_VALUE_W-1:0]   read_value_reg;
    logic signed [GRAD_W-1:0]        grad_x_reg;
    logic signed [GRAD_W-1:0]        grad_y_reg;
    logic                            status_reg;

    logic                            load;
    logic [CFG_W-1:0]                nrow;
    logic [CFG_W-1:0]                ncol;
    logic [2*CFG_W-1:0]              prod;
    logic [ADDR_CALC_W-1:0]          addr_calc;
    logic signed [VALUE_BITS-1:0]    rdata_s;
    logic signed [DIFF_W-1:0]        diff;
    logic signed [RV_W-1:0]          rv_ext;
    logic                            is_grad;

    assign load    = ((state_reg == ST_IDLE) || (state_reg == ST_DONE)) && !q_empty;
    assign q_pop   = load;
    assign is_grad = (desc_reg.kind == REQ_GRAD);

    // Gradient order: right, left, upper, lower neighbor.
    always_comb
    begin
        nrow = CFG_W'(desc_reg.row);
        ncol = CFG_W'(desc_reg.col);
        if (is_grad)
        begin
            case (step_reg)
                2'd0:    ncol = CFG_W'(desc_reg.col) + 8'd1;
                2'd1:    ncol = CFG_W'(desc_reg.col) - 8'd1;
                2'd2:    nrow = CFG_W'(desc_reg.row) - 8'd1;
                2'd3:    nrow = CFG_W'(desc_reg.row) + 8'd1;
                default: ;
            endcase
        end
    end

    assign prod      = (2*CFG_W)'(nrow) * (2*CFG_W)'(eff_w);
    assign addr_calc = ADDR_CALC_W'(prod + (2*CFG_W)'(ncol));
    assign ram_addr  = ADDR_W'(addr_calc);
    assign ram_wdata = VALUE_BITS'(desc_reg.value);
    assign ram_we    = (state_reg == ST_RUN) && (desc_reg.kind == REQ_WRITE)
                    && desc_reg.access;
    assign ram_re    = (state_reg == ST_RUN) && desc_reg.access
                    && ((desc_reg.kind == REQ_READ) || is_grad);

    assign rdata_s = ram_rdata;
    assign diff    = DIFF_W'(hold_reg) - DIFF_W'(rdata_s);
    assign rv_ext  = RV_W'(rdata_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= 2'd0;
            pend_reg         <= 1'b0;
            pend_step_reg    <= 2'd0;
            result_valid_reg <= 1'b0;
            read_value_reg   <= '0;
            grad_x_reg       <= '0;
            grad_y_reg       <= '0;
            status_reg       <= 1'b0;
        end
        else
        begin
            pend_reg         <= ram_re;
            pend_step_reg    <= step_reg;
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (load)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= 2'd0;
                    end
                end
                ST_RUN:
                begin
                    if (desc_reg.kind == REQ_WRITE)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (is_grad && desc_reg.access && (step_reg != 2'd3))
                    begin
                        step_reg <= step_reg + 2'd1;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    result_valid_reg <= 1'b1;
                    status_reg       <= desc_reg.status;
                    read_value_reg   <= (!is_grad && pend_reg) ? rv_ext[OUT_VALUE_W-1:0] : '0;
                    grad_x_reg       <= is_grad ? gx_reg : '0;
                    grad_y_reg       <= (is_grad && pend_reg) ? diff[GRAD_W-1:0] : '0;
                    if (load)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= 2'd0;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= q_data;
            gx_reg   <= '0;
        end
        else if (pend_reg && is_grad)
        begin
            case (pend_step_reg)
                2'd0:    hold_reg <= rdata_s;
                2'd1:    gx_reg   <= diff[GRAD_W-1:0];
                2'd2:    hold_reg <= rdata_s;
                default: ;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;
    assign grad_x       = grad_x_reg;
    assign grad_y       = grad_y_reg;
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held longer than one cycle");
    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("grid memory written and read in the same cycle");
    a_done_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> result_valid_reg)
        else $error("finished request gave no result word");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("request taken from an empty queue");
`endif

endmodule

`default_nettype wire

### src/grid_cell_read_and_gradient.sv
// Top level of the grid cell store with cell read and central-difference gradient.
`timescale 1ns / 1ps
`default_nettype none

// A command word is taken at a clock edge where start is high and busy is low.
// Writes and reads address one cell of a row-major grid; a gradient request
// returns the undivided central differences (right minus left, upper row minus
// lower row) around the cell, clamped to the border or restricted to interior
// cells as the safe_gradient register selects. A read or a gradient gives one
// result word, shown for exactly one cycle with result_valid high; the receiver
// cannot stall it, so it must take the word in that cycle. Writes, and commands
// with an unused request code, give no word. The front end classifies each
// command against the configured grid size and places it in a two-entry queue,
// so the host can keep issuing while the back end works; busy rises only when
// that queue is full. The back end owns the single-port grid memory and reaches
// it once per cycle; a gradient makes four neighbor reads in successive cycles,
// and the next request is taken from the queue while the result word of the
// last is formed. The grid memory has no reset and no clearing pass: cells
// must be written before they are read. Configuration writes are always
// accepted (cfg_ready is tied high) and are only to be made while no command
// is pending.
module grid_cell_read_and_gradient #(
    parameter int MAX_WIDTH  = gcrg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gcrg_pkg::DEF_MAX_HEIGHT,
    parameter int VALUE_BITS = gcrg_pkg::DEF_VALUE_BITS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [gcrg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [gcrg_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic [1:0]                              req_type,
    input  wire logic [gcrg_pkg::ROW_W-1:0]              row,
    input  wire logic [gcrg_pkg::COL_W-1:0]              col,
    input  wire logic signed [gcrg_pkg::IN_VALUE_W-1:0]  cell_value,
    output logic                                         result_valid,
    output logic signed [gcrg_pkg::OUT_VALUE_W-1:0]      read_value,
    output logic signed [gcrg_pkg::GRAD_W-1:0]           grad_x,
    output logic signed [gcrg_pkg::GRAD_W-1:0]           grad_y,
    output logic                                         status
);
    import gcrg_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                  push;
    desc_t                 push_data;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    desc_t                 q_data;
    logic [CFG_W-1:0]      eff_w;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_addr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Register writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    gcrg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .req_type   (req_type),
        .row        (row),
        .col        (col),
        .cell_value (cell_value),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data),
        .eff_w      (eff_w)
    );

    gcrg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    gcrg_back #(
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .eff_w        (eff_w),
        .ram_we       (ram_we),
        .ram_re       (ram_re),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .result_valid (result_valid),
        .read_value   (read_value),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .status       (status)
    );

    gcrg_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### tb/sv/gradient_board_pkg.sv
// Scoreboard class that predicts and checks the result words of the grid block.
`timescale 1ns / 1ps

package gradient_board_pkg;

    import gcrg_pkg::*;

    localparam int GRID_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct {
        logic signed [OUT_VALUE_W-1:0] read_value;
        logic signed [GRAD_W-1:0]      grad_x;
        logic signed [GRAD_W-1:0]      grad_y;
        logic                          status;
    } result_word_t;

    class gradient_board;
        logic signed [IN_VALUE_W-1:0] cells [GRID_CELLS];
        bit                           filled [GRID_CELLS];
        logic [CFG_W-1:0]             width_reg;
        logic [CFG_W-1:0]             height_reg;
        logic                         safe_reg;
        result_word_t                 awaited_words [$];
        int                           errors;

        function new();
            width_reg  = GRID_SIZE_RESET;
            height_reg = GRID_SIZE_RESET;
            safe_reg   = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned cols_in_use();
            if (width_reg < MIN_SIZE)
                return MIN_SIZE;
            if (width_reg > DEF_MAX_WIDTH)
                return DEF_MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned rows_in_use();
            if (height_reg < MIN_SIZE)
                return MIN_SIZE;
            if (height_reg > DEF_MAX_HEIGHT)
                return DEF_MAX_HEIGHT;
            return height_reg;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
            case (idx)
                CFG_GRID_WIDTH:    width_reg  = data;
                CFG_GRID_HEIGHT:   height_reg = data;
                CFG_SAFE_GRADIENT: safe_reg   = data[0];
                default:           ;
            endcase
        endfunction

        // Finds the cells that a read or a gradient touches and the status it reports.
        // For a gradient the order is right, left, upper, lower.
        function void locate(input logic [1:0] kind, input logic [ROW_W-1:0] row_in,
                             input logic [COL_W-1:0] col_in, output int unsigned used,
                             output int unsigned addr [4], output logic flag);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            bit          in_grid;
            bit          go;
            w       = cols_in_use();
            h       = rows_in_use();
            r       = row_in;
            c       = col_in;
            in_grid = (r < h) && (c < w);
            used    = 0;
            flag    = 1'b0;
            go      = 1'b0;
            foreach (addr[i])
                addr[i] = 0;
            if (kind == REQ_READ)
            begin
                if (in_grid)
                begin
                    used    = 1;
                    addr[0] = r * w + c;
                end
                else
                    flag = 1'b1;
            end
            else if (kind == REQ_GRAD)
            begin
                if (safe_reg)
                    go = (r >= 1) && (r + 1 < h) && (c >= 1) && (c + 1 < w);
                else
                begin
                    go   = in_grid;
                    flag = !in_grid;
                    if (r < 1)
                        r = 1;
                    if (c < 1)
                        c = 1;
                    if (r > h - 2)
                        r = h - 2;
                    if (c > w - 2)
                        c = w - 2;
                end
                if (go)
                begin
                    used    = 4;
                    addr[0] = r * w + c + 1;
                    addr[1] = r * w + c - 1;
                    addr[2] = (r - 1) * w + c;
                    addr[3] = (r + 1) * w + c;
                end
            end
        endfunction

        // Address of the first cell a request would read before it was written, or -1.
        function int first_blank(input logic [1:0] kind, input logic [ROW_W-1:0] r,
                                 input logic [COL_W-1:0] c);
            int unsigned used;
            int unsigned addr [4];
            logic        flag;
            locate(kind, r, c, used, addr, flag);
            for (int i = 0; i < used; i++)
                if (!filled[addr[i]])
                    return addr[i];
            return -1;
        endfunction

        // Updates the grid copy for an accepted word and queues the word it should cause.
        function void note_command(input logic [1:0] kind, input logic [ROW_W-1:0] r,
                                   input logic [COL_W-1:0] c,
                                   input logic signed [IN_VALUE_W-1:0] value);
            int unsigned  used;
            int unsigned  addr [4];
            logic         flag;
            int unsigned  a;
            result_word_t word;
            if (kind == REQ_WRITE)
            begin
                if (r < rows_in_use() && c < cols_in_use())
                begin
                    a         = r * cols_in_use() + c;
                    cells[a]  = value;
                    filled[a] = 1'b1;
                end
            end
            else if (kind == REQ_READ || kind == REQ_GRAD)
            begin
                locate(kind, r, c, used, addr, flag);
                word.read_value = '0;
                word.grad_x     = '0;
                word.grad_y     = '0;
                word.status     = flag;
                if (kind == REQ_READ && used != 0)
                    word.read_value = cells[addr[0]];
                if (kind == REQ_GRAD && used != 0)
                begin
                    word.grad_x = GRAD_W'(int'(cells[addr[0]]) - int'(cells[addr[1]]));
                    word.grad_y = GRAD_W'(int'(cells[addr[2]]) - int'(cells[addr[3]]));
                end
                awaited_words.push_back(word);
            end
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(input result_word_t got);
            result_word_t want;
            if (awaited_words.size() == 0)
            begin
                report($sformatf("result word with none awaited: value %0d gx %0d gy %0d st %0b",
                                 got.read_value, got.grad_x, got.grad_y, got.status));
                return;
            end
            want = awaited_words.pop_front();
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %0d, expected %0d", got.read_value,
                                 want.read_value));
            if (got.grad_x !== want.grad_x)
                report($sformatf("grad_x %0d, expected %0d", got.grad_x, want.grad_x));
            if (got.grad_y !== want.grad_y)
                report($sformatf("grad_y %0d, expected %0d", got.grad_y, want.grad_y));
            if (got.status !== want.status)
                report($sformatf("status %0b, expected %0b", got.status, want.status));
        endtask

        task close_out();
            if (awaited_words.size() != 0)
                report($sformatf("%0d result words never arrived", awaited_words.size()));
        endtask
    endclass

endpackage

### tb/sv/testbench.sv
// Top-level testbench of the grid cell read and gradient block.
`timescale 1ns / 1ps

module testbench;

    import gcrg_pkg::*;
    import gradient_board_pkg::*;

    // A phase ends with no word moving for a while; the watchdog sits well above that.
    localparam int IDLE_LIMIT      = 1000;
    // Cycles granted after the last result word so that trailing writes finish.
    localparam int SETTLE_CYCLES   = 32;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 135;

    // Request code with no meaning and register index with no register; both are ignored.
    localparam logic [1:0]           REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index  = '0;
    logic [CFG_W-1:0]              cfg_data   = '0;
    logic                          start      = 1'b0;
    logic                          busy;
    logic [1:0]                    req_type   = '0;
    logic [ROW_W-1:0]              row        = '0;
    logic [COL_W-1:0]              col        = '0;
    logic signed [IN_VALUE_W-1:0]  cell_value = '0;
    logic                          result_valid;
    logic signed [OUT_VALUE_W-1:0] read_value;
    logic signed [GRAD_W-1:0]      grad_x;
    logic signed [GRAD_W-1:0]      grad_y;
    logic                          status;

    gradient_board board;
    result_word_t  seen;
    int unsigned   quiet_cycles = 0;
    int unsigned   words_sent   = 0;
    bit            no_gaps      = 1'b0;
    // Corner of a small window that most random requests of a phase land in, so that
    // reads and gradients find written cells even on the full-size grid.
    int unsigned   win_row      = 0;
    int unsigned   win_col      = 0;

    grid_cell_read_and_gradient u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver cannot hold a result word off, so every cycle with result_valid
    // high carries exactly one word, and it is compared at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seen.read_value = read_value;
            seen.grad_x     = grad_x;
            seen.grad_y     = grad_y;
            seen.status     = status;
            board.check_result(seen);
        end
    end

    // Watchdog: any command, result or register word moving clears the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Holds one command word on the ports until the block takes it. start stays high
    // on return, so a following word goes out back to back.
    task automatic send_word(input logic [1:0] kind, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c,
                             input logic signed [IN_VALUE_W-1:0] v);
        start      <= 1'b1;
        req_type   <= kind;
        row        <= r;
        col        <= c;
        cell_value <= v;
        do
            @(posedge clk);
        while (busy);
        board.note_command(kind, r, c, v);
        words_sent++;
    endtask

    // The sender pauses before roughly a quarter of its words, except in the phase
    // without gaps. Fields carry junk while start is low, which the block must ignore.
    task automatic pause_sender();
        if (!no_gaps && $urandom_range(99) < 26)
        begin
            start      <= 1'b0;
            req_type   <= 2'($urandom);
            row        <= ROW_W'($urandom);
            col        <= COL_W'($urandom);
            cell_value <= IN_VALUE_W'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
    endtask

    // Sends a request, first writing random values into any cell it would read that
    // has not been written yet, since the grid memory holds junk until written.
    task automatic issue(input logic [1:0] kind, input logic [ROW_W-1:0] r,
                         input logic [COL_W-1:0] c,
                         input logic signed [IN_VALUE_W-1:0] v);
        int blank;
        blank = board.first_blank(kind, r, c);
        while (blank >= 0)
        begin
            pause_sender();
            send_word(REQ_WRITE, ROW_W'(blank / board.cols_in_use()),
                      COL_W'(blank % board.cols_in_use()), IN_VALUE_W'($urandom));
            blank = board.first_blank(kind, r, c);
        end
        pause_sender();
        send_word(kind, r, c, v);
    endtask

    // Stops sending and waits for every awaited word, then lets trailing writes finish.
    // This is the only point where registers may change.
    task automatic drain();
        start <= 1'b0;
        while (board.awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so that register words can follow one another.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] safe_data);
        write_register(CFG_GRID_WIDTH, w);
        write_register(CFG_GRID_HEIGHT, h);
        write_register(CFG_SAFE_GRADIENT, safe_data);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed requests inside a window of the grid, some anywhere in the
    // grid, and some with indices anywhere in the field range. A few use the
    // unused request code.
    task automatic random_request();
        int unsigned      pick;
        logic [1:0]       kind;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        pick = $urandom_range(99);
        if (pick < 25)
            kind = REQ_WRITE;
        else if (pick < 55)
            kind = REQ_READ;
        else if (pick < 94)
            kind = REQ_GRAD;
        else
            kind = REQ_UNUSED;
        case ($urandom_range(4))
            0:
            begin
                r = ROW_W'($urandom);
                c = COL_W'($urandom);
            end
            1:
            begin
                r = ROW_W'($urandom_range(board.rows_in_use() - 1));
                c = COL_W'($urandom_range(board.cols_in_use() - 1));
            end
            default:
            begin
                r = ROW_W'(win_row + $urandom_range(7));
                c = COL_W'(win_col + $urandom_range(7));
            end
        endcase
        issue(kind, r, c, IN_VALUE_W'($urandom));
    endtask

    initial
    begin
        int unsigned phase_end;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size grid, clamp mode. The neighbors of (1,1) hold the extreme values,
        // so its gradient reaches the largest magnitudes of both outputs.
        issue(REQ_WRITE, 7'd1, 7'd2, 16'sh7FFF);
        issue(REQ_WRITE, 7'd1, 7'd0, 16'sh8000);
        issue(REQ_WRITE, 7'd0, 7'd1, 16'sh8000);
        issue(REQ_WRITE, 7'd2, 7'd1, 16'sh7FFF);
        issue(REQ_GRAD, 7'd1, 7'd1, 16'sh0000);
        // The corner clamps onto the same interior cell.
        issue(REQ_GRAD, 7'd0, 7'd0, 16'sh0000);
        issue(REQ_READ, 7'd0, 7'd1, 16'sh0000);
        issue(REQ_READ, 7'd1, 7'd2, 16'sh0000);
        issue(REQ_UNUSED, 7'd5, 7'd5, 16'sh1234);
        // Far corner clamps to the row and column next to the border.
        issue(REQ_GRAD, 7'd127, 7'd127, 16'sh0000);

        // Sizes below the minimum saturate to 3 by 3; safe mode from bit 0 of all ones.
        // A word to the unused register index must change nothing.
        drain();
        write_register(CFG_UNUSED, 8'hFF);
        configure(8'd0, 8'd2, 8'hFF);
        issue(REQ_GRAD, 7'd1, 7'd1, 16'sh0000);
        issue(REQ_GRAD, 7'd0, 7'd1, 16'sh0000);
        issue(REQ_GRAD, 7'd9, 7'd9, 16'sh0000);
        issue(REQ_READ, 7'd3, 7'd0, 16'sh0000);
        issue(REQ_WRITE, 7'd0, 7'd3, 16'sh5555);
        issue(REQ_READ, 7'd2, 7'd2, 16'sh0000);

        // Width above the maximum saturates to 128; clamp mode with the upper bits set.
        drain();
        configure(8'hFF, 8'd3, 8'hFE);
        issue(REQ_GRAD, 7'd2, 7'd127, 16'sh0000);
        issue(REQ_GRAD, 7'd3, 7'd0, 16'sh0000);
        issue(REQ_WRITE, 7'd3, 7'd3, 16'shAAAA);
        issue(REQ_READ, 7'd0, 7'd127, 16'sh0000);

        // Random phases, each under its own grid size and gradient mode. The drain
        // before each phase also makes the sender wait until every word has come.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                0:       configure(8'd4, 8'd5, {7'($urandom), 1'b0});
                1:       configure(8'd128, 8'd128, {7'($urandom), 1'b1});
                2:       configure(8'd255, 8'd0, {7'($urandom), 1'b0});
                default:
                begin
                    if ($urandom_range(1) == 0)
                        configure(8'($urandom_range(3, 20)), 8'($urandom_range(3, 20)),
                                  {7'($urandom), p[0]});
                    else
                        configure(8'($urandom), 8'($urandom), {7'($urandom), p[0]});
                end
            endcase
            no_gaps   = (p == 3);
            win_row   = $urandom_range(board.rows_in_use() - 1);
            win_col   = $urandom_range(board.cols_in_use() - 1);
            phase_end = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end)
                random_request();
        end

        drain();
        board.close_out();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
